[design/clr_pkg.sv]
package clr_pkg;

    // Stream field widths
    localparam int COORD_IN_W = 12;
    localparam int COLOR_W    = 32;
    localparam int CFG_W      = 12;
    localparam int PIX_W      = 11;
    localparam int ADDR_W     = 24;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 80;

    // Four bytes per pixel
    localparam int BPP_SHIFT  = 2;

    // Bresenham bookkeeping
    localparam int DELTA_W    = 13;
    localparam int ERR_W      = 15;

    // Register reset values
    localparam logic [CFG_W-1:0] FB_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FB_HEIGHT_RST = 12'd480;

    // Command codes carried in tuser
    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_FB_WIDTH  = 1'b0;
    localparam logic CFG_FB_HEIGHT = 1'b1;

    // Pending pixel control between step and pixel stages
    typedef struct packed {
        logic valid;
        logic last;
    } t_pix_ctl;

endpackage

[design/clr_step.sv]
module clr_step #(
    parameter int CW = 13,
    parameter int WW = 12,
    parameter int HW = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_take,
    input  logic                                i_func,
    input  logic signed [clr_pkg::COORD_IN_W-1:0] i_begin_x,
    input  logic signed [clr_pkg::COORD_IN_W-1:0] i_begin_y,
    input  logic signed [clr_pkg::COORD_IN_W-1:0] i_end_x,
    input  logic signed [clr_pkg::COORD_IN_W-1:0] i_end_y,
    input  logic [clr_pkg::COLOR_W-1:0]         i_color,
    input  logic [WW-1:0]                       i_w_eff,
    input  logic [HW-1:0]                       i_h_eff,
    input  logic                                i_move,
    output clr_pkg::t_pix_ctl                   o_ctl,
    output logic signed [CW-1:0]                o_cur_x,
    output logic signed [CW-1:0]                o_cur_y,
    output logic [clr_pkg::COLOR_W-1:0]         o_color
);
    import clr_pkg::*;

    logic signed [CW-1:0]      r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic signed [CW-1:0]      n_cur_x, n_cur_y, n_tgt_x, n_tgt_y;
    logic signed [DELTA_W-1:0] r_dx, r_dy, n_dx, n_dy;
    logic                      r_sxn, r_syn, n_sxn, n_syn;
    logic signed [ERR_W-1:0]   r_err, n_err;
    logic [COLOR_W-1:0]        r_color, n_color;
    logic                      r_active, n_active;
    t_pix_ctl                  r_ctl;

    logic signed [CW-1:0]      cx, cy;
    logic signed [DELTA_W-1:0] ddx, ddy, adx, ady;
    logic signed [ERR_W:0]     e2;
    logic                      step_x, step_y;
    logic                      emit, is_last;

    // centre is floor(dim / 2)
    assign cx = $signed(CW'(i_w_eff >> 1));
    assign cy = $signed(CW'(i_h_eff >> 1));

    // deltas come straight from the relative endpoints, the centre cancels
    assign ddx = DELTA_W'(i_end_x) - DELTA_W'(i_begin_x);
    assign ddy = DELTA_W'(i_end_y) - DELTA_W'(i_begin_y);
    assign adx = (ddx < 0) ? -ddx : ddx;
    assign ady = (ddy < 0) ? -ddy : ddy;

    assign e2     = {r_err, 1'b0};
    assign step_x = e2 > -(ERR_W+1)'(r_dy);
    assign step_y = e2 < (ERR_W+1)'(r_dx);

    always_comb begin
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_tgt_x  = r_tgt_x;
        n_tgt_y  = r_tgt_y;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_sxn    = r_sxn;
        n_syn    = r_syn;
        n_err    = r_err;
        n_color  = r_color;
        if (i_func == FUNC_START) begin
            n_cur_x = cx + CW'(i_begin_x);
            n_cur_y = cy + CW'(i_begin_y);
            n_tgt_x = cx + CW'(i_end_x);
            n_tgt_y = cy + CW'(i_end_y);
            n_dx    = adx;
            n_dy    = ady;
            n_sxn   = (ddx <= 0);
            n_syn   = (ddy <= 0);
            n_err   = ERR_W'(adx) - ERR_W'(ady);
            n_color = i_color;
        end else begin
            n_err = r_err - (step_x ? ERR_W'(r_dy) : ERR_W'(0))
                          + (step_y ? ERR_W'(r_dx) : ERR_W'(0));
            if (step_x) begin
                n_cur_x = r_sxn ? r_cur_x - CW'(1) : r_cur_x + CW'(1);
            end
            if (step_y) begin
                n_cur_y = r_syn ? r_cur_y - CW'(1) : r_cur_y + CW'(1);
            end
        end
    end

    assign emit     = i_take && ((i_func == FUNC_START) || r_active);
    assign is_last  = (n_cur_x == n_tgt_x) && (n_cur_y == n_tgt_y);
    assign n_active = emit ? !is_last : r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_ctl     <= '0;
        end else begin
            r_active <= n_active;
            if (emit) begin
                r_ctl.valid <= 1'b1;
                r_ctl.last  <= is_last;
            end else if (i_move) begin
                r_ctl.valid <= 1'b0;
            end
        end
    end

    // line state only moves on an emitting transfer
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_tgt_x <= n_tgt_x;
            r_tgt_y <= n_tgt_y;
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_sxn   <= n_sxn;
            r_syn   <= n_syn;
            r_err   <= n_err;
            r_color <= n_color;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_cur_x = r_cur_x;
    assign o_cur_y = r_cur_y;
    assign o_color = r_color;

endmodule

[design/clr_pixel.sv]
module clr_pixel #(
    parameter int CW  = 13,
    parameter int WW  = 12,
    parameter int HW  = 12,
    parameter int PXW = 11,
    parameter int PYW = 11
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic                        i_out_ready,
    input  clr_pkg::t_pix_ctl           i_ctl,
    input  logic signed [CW-1:0]        i_cur_x,
    input  logic signed [CW-1:0]        i_cur_y,
    input  logic [clr_pkg::COLOR_W-1:0] i_color,
    input  logic [WW-1:0]               i_w_eff,
    input  logic [HW-1:0]               i_h_eff,
    output logic                        o_valid,
    output logic [clr_pkg::PIX_W-1:0]   o_pixel_x,
    output logic [clr_pkg::PIX_W-1:0]   o_pixel_y,
    output logic [clr_pkg::ADDR_W-1:0]  o_byte_address,
    output logic [clr_pkg::COLOR_W-1:0] o_color,
    output logic                        o_last
);
    import clr_pkg::*;

    localparam int LIN_W   = ADDR_W - BPP_SHIFT;
    localparam int PROD_W  = PYW + WW + 1;
    localparam int MUL_W   = (PROD_W > LIN_W) ? PROD_W : LIN_W;

    logic signed [CW-1:0] w_m1, h_m1, x_hi, y_hi;
    logic [PXW-1:0]       px;
    logic [PYW-1:0]       py;
    logic [MUL_W-1:0]     lin;

    logic                 r_valid;
    logic [PIX_W-1:0]     r_px, r_py;
    logic [ADDR_W-1:0]    r_addr;
    logic [COLOR_W-1:0]   r_color;
    logic                 r_last;

    assign w_m1 = $signed(CW'(i_w_eff)) - CW'(1);
    assign h_m1 = $signed(CW'(i_h_eff)) - CW'(1);
    assign x_hi = (i_cur_x < w_m1) ? i_cur_x : w_m1;
    assign y_hi = (i_cur_y < h_m1) ? i_cur_y : h_m1;
    assign px   = (x_hi > 0) ? PXW'(x_hi) : '0;
    assign py   = (y_hi > 0) ? PYW'(y_hi) : '0;

    // row * width + column, in pixels
    assign lin = MUL_W'(py) * MUL_W'(i_w_eff) + MUL_W'(px);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_px    <= PIX_W'(px);
            r_py    <= PIX_W'(py);
            r_addr  <= {lin[LIN_W-1:0], {BPP_SHIFT{1'b0}}};
            r_color <= i_color;
            r_last  <= i_ctl.last;
        end
    end

    assign o_valid        = r_valid;
    assign o_pixel_x      = r_px;
    assign o_pixel_y      = r_py;
    assign o_byte_address = r_addr;
    assign o_color        = r_color;
    assign o_last         = r_last;

endmodule

[design/clamped_line_rasterizer.sv]
// Channel    | Direction | Handshake                     | Carries
// s_axis     | in        | s_axis_tvalid / s_axis_tready | endpoints, color; tuser = func
// m_axis     | out       | m_axis_tvalid / m_axis_tready | pixel, address, color; tlast = end
// i_cfg      | in        | i_cfg_we (no wait)            | fb_width (idx 0), fb_height (idx 1)
//
// One transfer per clock while m_axis is not stalled; a pixel is registered in stage one, then in stage two.
// Stage one (clr_step) runs the Bresenham step or line setup on the accepting edge,
// stage two (clr_pixel) clamps, multiplies row by width and registers the result.
// Synchronous active-low reset; the line goes idle and both stages empty.
// Output stall holds the result register; one more pixel waits in stage one, so
// s_axis_tready drops only when both are full.
module clamped_line_rasterizer #(
    parameter int MAX_W = 2048,
    parameter int MAX_H = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // s_axis
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [11:0] begin_x, [23:12] begin_y, [35:24] end_x, [47:36] end_y,
    // [55:48] color_red, [63:56] color_green, [71:64] color_blue, [79:72] color_alpha
    input  logic [clr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] func
    input  logic                           s_axis_tuser,
    // m_axis
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [10:0] pixel_x, [21:11] pixel_y, [45:22] byte_address, [53:46] out_red,
    // [61:54] out_green, [69:62] out_blue, [77:70] out_alpha, [79:78] zero
    output logic [clr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast,
    // configuration
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [clr_pkg::CFG_W-1:0]      i_cfg_data
);
    import clr_pkg::*;

    localparam int PXW   = $clog2(MAX_W);
    localparam int PYW   = $clog2(MAX_H);
    localparam int WW    = $clog2(MAX_W + 1);
    localparam int HW    = $clog2(MAX_H + 1);
    localparam int MAXB  = (PXW > PYW) ? PXW : PYW;
    // room for centre plus the widest relative offset, and sign
    localparam int CW    = ((MAXB > COORD_IN_W - 1) ? MAXB : COORD_IN_W - 1) + 2;

    logic [CFG_W-1:0]   r_fb_width, r_fb_height;
    logic [WW-1:0]      w_eff;
    logic [HW-1:0]      h_eff;

    t_pix_ctl             pend_ctl;
    logic signed [CW-1:0] pend_x, pend_y;
    logic [COLOR_W-1:0]   pend_color;
    logic                 move, take;

    logic [PIX_W-1:0]   pixel_x, pixel_y;
    logic [ADDR_W-1:0]  byte_address;
    logic [COLOR_W-1:0] out_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_width  <= FB_WIDTH_RST;
            r_fb_height <= FB_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FB_WIDTH:  r_fb_width  <= i_cfg_data;
                CFG_FB_HEIGHT: r_fb_height <= i_cfg_data;
                default:       r_fb_width  <= r_fb_width;
            endcase
        end
    end

    // zero reads as one, oversize saturates to the maximum
    always_comb begin
        priority if (r_fb_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_fb_width) > MAX_W) begin
            w_eff = WW'(MAX_W);
        end else begin
            w_eff = WW'(r_fb_width);
        end
        priority if (r_fb_height == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_fb_height) > MAX_H) begin
            h_eff = HW'(MAX_H);
        end else begin
            h_eff = HW'(r_fb_height);
        end
    end

    // pending pixel leaves stage one when the result register is free
    assign move          = pend_ctl.valid && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !pend_ctl.valid || move;
    assign take          = s_axis_tvalid && s_axis_tready;

    clr_step #(
        .CW (CW),
        .WW (WW),
        .HW (HW)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_func    (s_axis_tuser),
        .i_begin_x ($signed(s_axis_tdata[11:0])),
        .i_begin_y ($signed(s_axis_tdata[23:12])),
        .i_end_x   ($signed(s_axis_tdata[35:24])),
        .i_end_y   ($signed(s_axis_tdata[47:36])),
        .i_color   ({s_axis_tdata[55:48], s_axis_tdata[63:56],
                     s_axis_tdata[71:64], s_axis_tdata[79:72]}),
        .i_w_eff   (w_eff),
        .i_h_eff   (h_eff),
        .i_move    (move),
        .o_ctl     (pend_ctl),
        .o_cur_x   (pend_x),
        .o_cur_y   (pend_y),
        .o_color   (pend_color)
    );

    clr_pixel #(
        .CW  (CW),
        .WW  (WW),
        .HW  (HW),
        .PXW (PXW),
        .PYW (PYW)
    ) u_pixel (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (move),
        .i_out_ready    (m_axis_tready),
        .i_ctl          (pend_ctl),
        .i_cur_x        (pend_x),
        .i_cur_y        (pend_y),
        .i_color        (pend_color),
        .i_w_eff        (w_eff),
        .i_h_eff        (h_eff),
        .o_valid        (m_axis_tvalid),
        .o_pixel_x      (pixel_x),
        .o_pixel_y      (pixel_y),
        .o_byte_address (byte_address),
        .o_color        (out_color),
        .o_last         (m_axis_tlast)
    );

    // color kept as red in the top byte down to alpha in the bottom byte
    assign m_axis_tdata = {2'b00,
                           out_color[7:0], out_color[15:8],
                           out_color[23:16], out_color[31:24],
                           byte_address, pixel_y, pixel_x};

`ifndef NO_ASSERTIONS
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pend_ctl.valid |-> s_axis_tready)
        else $error("input stalled with stage one empty");

    a_start_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && s_axis_tuser == FUNC_START) |=> pend_ctl.valid)
        else $error("start transfer produced no pixel");

    a_pending_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pend_ctl.valid && !move) |=> pend_ctl.valid)
        else $error("pending pixel dropped");

    a_out_from_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(move))
        else $error("result appeared without a pending pixel");
`endif

endmodule

[bench/tb_clamped_line_rasterizer.sv]
`timescale 1ns / 100ps

module tb_clamped_line_rasterizer;
    import clr_pkg::*;

    localparam int LIM_W       = 2048;
    localparam int LIM_H       = 2048;
    localparam int QUIET_LIMIT = 4000;   // cycles with no transfer on either side
    localparam int PHASE_ITEMS = 244;    // counted items per frame-size phase
    localparam int NUM_PHASES  = 8;
    localparam int PRINT_CAP   = 40;

    // One line command as it travels on s_axis
    typedef struct {
        logic               func;
        logic signed [11:0] bx;
        logic signed [11:0] by;
        logic signed [11:0] ex;
        logic signed [11:0] ey;
        logic [31:0]        rgba;   // red in the top byte
    } t_line_cmd;

    // One plotted pixel as it travels on m_axis
    typedef struct {
        logic [10:0] px;
        logic [10:0] py;
        logic [23:0] addr;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        is_end;
    } t_pixel;

    typedef enum {RX_FREE, RX_COIN, RX_CHOKE, RX_PERIODIC} t_rx_mode;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata   = '0;
    logic                  s_axis_tuser   = FUNC_START;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_we       = 1'b0;
    logic                  i_cfg_idx      = CFG_FB_WIDTH;
    logic [CFG_W-1:0]      i_cfg_data     = '0;

    clamped_line_rasterizer #(
        .MAX_W(LIM_W),
        .MAX_H(LIM_H)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Line predictor: own copy of frame size and Bresenham state.
    // Runs once per accepted s_axis transfer, queues the pixel it causes.
    // ------------------------------------------------------------------
    int          fbw_raw = FB_WIDTH_RST;    // register contents, 12 bits
    int          fbh_raw = FB_HEIGHT_RST;
    int          pen_x, pen_y, goal_x, goal_y;
    int          run_x, run_y, err_acc;
    bit          x_back, y_back, drawing;
    logic [31:0] ink;

    t_line_cmd   cmd_pending[$];    // commands waiting for the driver
    t_pixel      pixel_expect[$];   // predicted pixels, oldest first
    int          mismatches = 0;

    // zero reads as one, oversize saturates
    function automatic int eff_size(input int raw, input int cap);
        if (raw == 0) return 1;
        if (raw > cap) return cap;
        return raw;
    endfunction

    function automatic int clamp_to(input int p, input int size);
        int r;
        r = (p < size - 1) ? p : size - 1;
        return (r > 0) ? r : 0;
    endfunction

    task automatic trace_pixel(input t_line_cmd c);
        int     w, h, px, py, e2;
        t_pixel pix;
        if (c.func == FUNC_START) begin
            // centre is latched here; later size writes only move clamping and address
            w       = eff_size(fbw_raw, LIM_W);
            h       = eff_size(fbh_raw, LIM_H);
            pen_x   = w / 2 + c.bx;
            pen_y   = h / 2 + c.by;
            goal_x  = w / 2 + c.ex;
            goal_y  = h / 2 + c.ey;
            run_x   = (goal_x > pen_x) ? goal_x - pen_x : pen_x - goal_x;
            run_y   = (goal_y > pen_y) ? goal_y - pen_y : pen_y - goal_y;
            x_back  = !(pen_x < goal_x);
            y_back  = !(pen_y < goal_y);
            err_acc = run_x - run_y;
            ink     = c.rgba;
            drawing = 1'b1;
        end else begin
            if (!drawing) return;   // advance while idle: no pixel
            e2 = 2 * err_acc;
            if (e2 > -run_y) begin
                err_acc -= run_y;
                pen_x   += x_back ? -1 : 1;
            end
            if (e2 < run_x) begin
                err_acc += run_x;
                pen_y   += y_back ? -1 : 1;
            end
        end
        // stepping stays unclamped; only the emitted pixel is clamped
        w          = eff_size(fbw_raw, LIM_W);
        h          = eff_size(fbh_raw, LIM_H);
        px         = clamp_to(pen_x, w);
        py         = clamp_to(pen_y, h);
        pix.px     = 11'(px);
        pix.py     = 11'(py);
        pix.addr   = 24'((py * w + px) << BPP_SHIFT);
        pix.red    = ink[31:24];
        pix.green  = ink[23:16];
        pix.blue   = ink[15:8];
        pix.alpha  = ink[7:0];
        pix.is_end = (pen_x == goal_x) && (pen_y == goal_y);
        if (pix.is_end) drawing = 1'b0;
        pixel_expect.push_back(pix);
    endtask

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int clip12(input int v);
        if (v < -2048) return -2048;
        if (v > 2047) return 2047;
        return v;
    endfunction

    function automatic int rand12();
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    task automatic push_cmd(input logic f, input int bx, input int by, input int ex,
                            input int ey, input logic [31:0] rgba);
        t_line_cmd c;
        c.func = f;
        c.bx   = 12'(bx);
        c.by   = 12'(by);
        c.ex   = 12'(ex);
        c.ey   = 12'(ey);
        c.rgba = rgba;
        cmd_pending.push_back(c);
    endtask

    // A start plus a run of advances. Mostly short lines walked to the end
    // point; the rest are long or cut short and get abandoned by the next
    // start. Advances carry random payload, which the block ignores.
    task automatic queue_stroke(output int counted);
        int bx, by, ex, ey, dx, dy, span, n_adv, pick;
        pick = $urandom_range(0, 99);
        bx   = rand12();
        by   = rand12();
        if (pick < 65) begin
            ex = clip12(bx + int'($urandom_range(0, 24)) - 12);
            ey = clip12(by + int'($urandom_range(0, 24)) - 12);
        end else if (pick < 80) begin
            bx = int'($urandom_range(0, 80)) - 40;
            by = int'($urandom_range(0, 80)) - 40;
            ex = int'($urandom_range(0, 80)) - 40;
            ey = int'($urandom_range(0, 80)) - 40;
        end else begin
            ex = rand12();
            ey = rand12();
        end
        dx   = (ex > bx) ? ex - bx : bx - ex;
        dy   = (ey > by) ? ey - by : by - ey;
        span = (dx > dy) ? dx : dy;
        if (span <= 40 && $urandom_range(0, 3) != 0)
            n_adv = span + $urandom_range(0, 2);   // finish, maybe idle extras
        else
            n_adv = $urandom_range(0, (span < 40) ? span : 40);
        push_cmd(FUNC_START, bx, by, ex, ey, $urandom);
        repeat (n_adv) push_cmd(FUNC_ADVANCE, rand12(), rand12(), rand12(), rand12(), $urandom);
        counted = 1 + ((n_adv < span) ? n_adv : span);
    endtask

    // Wait out all traffic, then the pipeline depth with margin so an
    // advance-while-idle still in flight cannot meet a register write.
    task automatic settle();
        while (cmd_pending.size() != 0 || s_axis_tvalid || pixel_expect.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Width then height on back-to-back edges; only called while idle
    task automatic set_frame(input int w, input int h);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FB_WIDTH;
        i_cfg_data <= 12'(w);
        fbw_raw     = w & 12'hFFF;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FB_HEIGHT;
        i_cfg_data <= 12'(h);
        fbh_raw     = h & 12'hFFF;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequencer: reset, directed lines at reset size, then one random phase
    // per frame size. A line left unfinished at a phase end is carried into
    // the next phase, so advances see a size change mid-line.
    // ------------------------------------------------------------------
    int frame_w[6] = '{1, 2048, 0, 4095, 3, 640};
    int frame_h[6] = '{1, 2048, 4095, 0, 2048, 480};

    initial begin
        int counted, n, w, h;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_cmd(FUNC_ADVANCE, 0, 0, 0, 0, 32'h0);                 // idle, no pixel
        push_cmd(FUNC_START, 0, 0, 0, 0, 32'h0000_0000);           // single-point line
        push_cmd(FUNC_ADVANCE, -1, -1, -1, -1, 32'hFFFF_FFFF);     // idle again
        push_cmd(FUNC_START, -2048, -2048, 2047, 2047, 32'hFFFF_FFFF);
        repeat (2) push_cmd(FUNC_ADVANCE, 0, 0, 0, 0, 32'h0);
        push_cmd(FUNC_START, 5, 3, -5, -3, 32'h1234_5678);         // abandons the diagonal
        repeat (11) push_cmd(FUNC_ADVANCE, 0, 0, 0, 0, 32'h0);     // last one idle
        push_cmd(FUNC_START, 0, 0, 1, -4, 32'hA5C3_E10F);          // steep, y leads
        repeat (4) push_cmd(FUNC_ADVANCE, 0, 0, 0, 0, 32'h0);
        push_cmd(FUNC_START, 2047, -2048, 2045, -2047, 32'h0F1E_2D3C);
        repeat (2) push_cmd(FUNC_ADVANCE, 0, 0, 0, 0, 32'h0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            w = (p < 6) ? frame_w[p] : $urandom_range(1, 2048);
            h = (p < 6) ? frame_h[p] : $urandom_range(1, 2048);
            set_frame(w, h);
            @(negedge i_clk);
            // leftover line, if any, steps on under the new frame size
            repeat (3) push_cmd(FUNC_ADVANCE, 0, 0, 0, 0, 32'h0);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                queue_stroke(n);
                counted += n;
            end
        end
        settle();

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: bursts of random length with random gaps, one transfer per
    // clock in a burst unless stalled; a command stays until its transfer.
    // ------------------------------------------------------------------
    t_line_cmd drv_cmd = '{func: FUNC_START, bx: '0, by: '0, ex: '0, ey: '0, rgba: '0};
    int        burst_left = 0;
    int        gap_left   = 0;

    always @(posedge i_clk) begin
        logic offer;
        offer = 1'b0;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                trace_pixel(drv_cmd);
            if (s_axis_tvalid && !s_axis_tready) begin
                offer = 1'b1;                      // stalled, hold the command
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (cmd_pending.size() != 0) begin
                drv_cmd = cmd_pending.pop_front();
                offer   = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    gap_left   = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 160)
                                                             : $urandom_range(0, 20);
                end
            end
        end
        s_axis_tvalid <= offer;
        s_axis_tuser  <= drv_cmd.func;
        s_axis_tdata  <= {drv_cmd.rgba[7:0], drv_cmd.rgba[15:8], drv_cmd.rgba[23:16],
                          drv_cmd.rgba[31:24], drv_cmd.ey, drv_cmd.ex, drv_cmd.by,
                          drv_cmd.bx};
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern switches between free, coin-flip, choked and
    // periodic modes. Once, after enough pixels, it holds off for a long
    // stretch so both pipeline stages fill and s_axis_tready drops.
    // ------------------------------------------------------------------
    t_rx_mode rx_mode    = RX_FREE;
    int       mode_left  = 0;
    int       rx_tick    = 0;
    int       rx_beats   = 0;
    int       hold_left  = 0;
    bit       held_off   = 1'b0;

    always @(posedge i_clk) begin
        logic nxt_ready;
        nxt_ready = 1'b1;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                rx_beats++;
            if (!held_off && rx_beats >= 600) begin
                held_off  = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 200);
                end else begin
                    mode_left--;
                end
                rx_tick++;
                case (rx_mode)
                    RX_FREE:     nxt_ready = 1'b1;
                    RX_COIN:     nxt_ready = $urandom_range(0, 1);
                    RX_CHOKE:    nxt_ready = ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: nxt_ready = (rx_tick % 3 == 0);
                    default:     nxt_ready = 1'b1;
                endcase
            end
        end
        m_axis_tready <= nxt_ready;
    end

    // ------------------------------------------------------------------
    // Monitor: each pixel transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pixel_expect.size() == 0) begin
                report_mismatch($sformatf("pixel with none predicted, tdata 0x%0h",
                                          m_axis_tdata));
            end else begin
                want = pixel_expect.pop_front();
                check_field("pixel_x",      m_axis_tdata[10:0],  want.px);
                check_field("pixel_y",      m_axis_tdata[21:11], want.py);
                check_field("byte_address", m_axis_tdata[45:22], want.addr);
                check_field("out_red",      m_axis_tdata[53:46], want.red);
                check_field("out_green",    m_axis_tdata[61:54], want.green);
                check_field("out_blue",     m_axis_tdata[69:62], want.blue);
                check_field("out_alpha",    m_axis_tdata[77:70], want.alpha);
                check_field("tdata pad",    m_axis_tdata[79:78], 32'd0);
                check_field("tlast",        m_axis_tlast,        want.is_end);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transfer means a hang
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule

[files.f]
design/clr_pkg.sv
design/clr_step.sv
design/clr_pixel.sv
design/clamped_line_rasterizer.sv
bench/tb_clamped_line_rasterizer.sv
